// ===== rtl/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// Counting semaphore table package
// Shared types, codes and helper functions for the semaphore table unit.
// ----------------------------------------------------------------------------
package cst_pkg;

    localparam int OP_W        = 2;
    localparam int REQUESTER_W = 3;
    localparam int INDEX_W     = 5;
    localparam int COUNT_W     = 16;
    localparam int STATUS_W    = 3;
    localparam int RESULT_W    = 4;

    // Width of the slice of the free map that is examined per cycle.
    localparam int GROUP_W  = 16;
    localparam int GROUP_AW = 4;

    localparam logic [COUNT_W-1:0]        COUNT_MAX = '1;
    localparam logic signed [INDEX_W-1:0] NEW_INDEX = -5'sd1;

    typedef enum logic [OP_W-1:0] {
        OP_GET  = 2'd0,
        OP_FREE = 2'd1,
        OP_DOWN = 2'd2,
        OP_UP   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_ERROR       = 3'd1,
        ST_NO_SLOT     = 3'd2,
        ST_NONE_FREE   = 3'd3,
        ST_BAD_INDEX   = 3'd4,
        ST_WOULD_BLOCK = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_EVAL   = 2'd1,
        S_SEARCH = 2'd2,
        S_RESP   = 2'd3
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]               operation;
        logic [REQUESTER_W-1:0]        requester;
        logic signed [INDEX_W-1:0]     sem_index;
        logic [COUNT_W-1:0]            start_count;
    } req_t;

    // Position of the lowest set bit; zero when no bit is set.
    function automatic logic [GROUP_AW-1:0] lowest_set(input logic [GROUP_W-1:0] vec);
        logic [GROUP_AW-1:0] pos;
        pos = '0;
        for (int i = GROUP_W - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                pos = GROUP_AW'(i);
            end
        end
        return pos;
    endfunction

endpackage

// ===== rtl/cst_if.sv =====
// ----------------------------------------------------------------------------
// Semaphore table channel interfaces
// Valid/ready channels for the request and the response transactions.
// ----------------------------------------------------------------------------
interface cst_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [cst_pkg::OP_W-1:0]              operation;
    logic [cst_pkg::REQUESTER_W-1:0]       requester;
    logic signed [cst_pkg::INDEX_W-1:0]    sem_index;
    logic [cst_pkg::COUNT_W-1:0]           start_count;

    modport source (output valid, operation, requester, sem_index, start_count,
                    input ready);
    modport sink   (input valid, operation, requester, sem_index, start_count,
                    output ready);
endinterface

interface cst_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [cst_pkg::STATUS_W-1:0]      status;
    logic [cst_pkg::RESULT_W-1:0]      result_index;

    modport source (output valid, status, result_index, input ready);
    modport sink   (input valid, status, result_index, output ready);
endinterface

// ===== rtl/cst_sem_store.sv =====
// ----------------------------------------------------------------------------
// Semaphore entry store
// Count and reference count per semaphore in a synchronous, registered-read memory,
// with an in-use flag per entry that stands in for the cleared reset state.
// ----------------------------------------------------------------------------
module cst_sem_store #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int REF_W  = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [ADDR_W-1:0]             rd_addr,
    output logic [cst_pkg::COUNT_W-1:0]   rd_count,
    output logic [REF_W-1:0]              rd_ref,
    input  logic                          we,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic [cst_pkg::COUNT_W-1:0]   wr_count,
    input  logic [REF_W-1:0]              wr_ref,
    output logic [DEPTH-1:0]              in_use
);

    logic [cst_pkg::COUNT_W+REF_W-1:0] sem_mem [DEPTH];
    logic [cst_pkg::COUNT_W+REF_W-1:0] rd_data_reg;
    logic [DEPTH-1:0]                  in_use_reg;
    logic                              rd_in_use_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            sem_mem[wr_addr] <= {wr_count, wr_ref};
        end
        if (rd_en)
        begin
            rd_data_reg <= sem_mem[rd_addr];
        end
    end

    // An entry whose reference count is zero is free; its stored count is
    // never consulted, so the flag alone gives the reset contents.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg    <= '0;
            rd_in_use_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                in_use_reg[wr_addr] <= (wr_ref != '0);
            end
            if (rd_en)
            begin
                rd_in_use_reg <= in_use_reg[rd_addr];
            end
        end
    end

    assign rd_count = rd_data_reg[cst_pkg::COUNT_W+REF_W-1:REF_W];
    assign rd_ref   = rd_in_use_reg ? rd_data_reg[REF_W-1:0] : '0;
    assign in_use   = in_use_reg;

endmodule

// ===== rtl/cst_slot_store.sv =====
// ----------------------------------------------------------------------------
// Requester slot store
// One row of held-semaphore tags per requester in a synchronous, registered-read
// memory; a row that was never written reads as all empty.
// ----------------------------------------------------------------------------
module cst_slot_store #(
    parameter int ROWS   = 8,
    parameter int ADDR_W = 3,
    parameter int ROW_W  = 20
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [ROW_W-1:0]  rd_row,
    input  logic              we,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [ROW_W-1:0]  wr_row
);

    logic [ROW_W-1:0] slot_mem [ROWS];
    logic [ROW_W-1:0] rd_data_reg;
    logic [ROWS-1:0]  row_valid_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            slot_mem[wr_addr] <= wr_row;
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    assign rd_row = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== rtl/counting_semaphore_table_unit.sv =====
// ----------------------------------------------------------------------------
// Counting semaphore table unit
// Requests enter on the req channel (operation, requester, sem_index,
// start_count) and each produces exactly one response transaction on the rsp
// channel (status, result_index). One request is processed at a time: it is
// accepted in the idle state, its semaphore entry and requester slot row are
// read in the same cycle, and the next cycle evaluates it and, on success,
// writes back the entry and, where it changes, the slot row; a get of a new
// semaphore instead scans the free map for the lowest free entry, in groups
// of 16 entries, and writes there. The response state then loads the result
// into the output register.
// The output register lets the next request be accepted while a response
// still waits; if the receiver stalls longer, the following response holds
// the unit in its response state and req.ready stays low.
// Reset clears the in-use flags and slot-row valid flags, so every semaphore
// starts free with no holders; no clearing pass is needed.
// ----------------------------------------------------------------------------
module counting_semaphore_table_unit #(
    parameter int NUM_SEMS            = 16,
    parameter int SLOTS_PER_REQUESTER = 4,
    parameter int NUM_REQUESTERS      = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    cst_req_if.sink   req,
    cst_rsp_if.source rsp
);

    localparam int SEM_AW  = $clog2(NUM_SEMS);
    localparam int REQ_AW  = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;
    localparam int SLOT_AW = (SLOTS_PER_REQUESTER > 1) ? $clog2(SLOTS_PER_REQUESTER) : 1;
    // A tag holds the semaphore number plus one; zero marks an empty slot.
    localparam int TAG_W   = $clog2(NUM_SEMS + 1);
    localparam int ROW_W   = SLOTS_PER_REQUESTER * TAG_W;
    localparam int REF_W   = $clog2(NUM_REQUESTERS * SLOTS_PER_REQUESTER + 1);
    localparam int NUM_GROUPS = (NUM_SEMS + cst_pkg::GROUP_W - 1) / cst_pkg::GROUP_W;
    localparam int GRP_W   = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int PAD_W   = NUM_GROUPS * cst_pkg::GROUP_W;
    localparam logic [GRP_W-1:0] LAST_GRP = GRP_W'(NUM_GROUPS - 1);

    cst_pkg::state_t  state_reg, state_next;
    cst_pkg::req_t    req_reg;
    cst_pkg::status_t status_reg, status_next;
    logic [cst_pkg::RESULT_W-1:0] result_reg, result_next;
    logic [GRP_W-1:0] grp_reg, grp_next;
    logic             out_valid_reg, out_valid_next;
    logic [cst_pkg::STATUS_W-1:0] out_status_reg;
    logic [cst_pkg::RESULT_W-1:0] out_index_reg;

    logic accept;
    logic out_load;
    logic go_search;

    // Entry store signals.
    logic [cst_pkg::COUNT_W-1:0] sem_count;
    logic [REF_W-1:0]            sem_ref;
    logic                        sem_we;
    logic [SEM_AW-1:0]           sem_wr_addr;
    logic [cst_pkg::COUNT_W-1:0] sem_wr_count;
    logic [REF_W-1:0]            sem_wr_ref;
    logic [NUM_SEMS-1:0]         in_use;

    // Slot store signals.
    logic [ROW_W-1:0] slot_row;
    logic             slot_we;
    logic [ROW_W-1:0] slot_wr_row;

    // Decoded request.
    logic [3:0]        idx_mag;
    logic [SEM_AW-1:0] idx_addr;
    logic [TAG_W-1:0]  idx_tag;
    logic              idx_in_range;
    logic              is_new;
    logic              req_ok;
    logic              sem_held;

    // Slot row search.
    logic               any_empty;
    logic [SLOT_AW-1:0] empty_pos;
    logic               any_match;
    logic [SLOT_AW-1:0] match_pos;

    // Free entry scan, one group of entries per cycle.
    logic [NUM_SEMS-1:0]                free_vec;
    logic [PAD_W-1:0]                   free_pad;
    logic [cst_pkg::GROUP_W-1:0]        grp_vec;
    logic                               grp_found;
    logic [cst_pkg::GROUP_AW-1:0]       found_pos;
    logic [SEM_AW-1:0]                  found_entry;
    logic [TAG_W-1:0]                   found_tag;

    assign accept = req.valid && req.ready;

    cst_sem_store #(
        .DEPTH  (NUM_SEMS),
        .ADDR_W (SEM_AW),
        .REF_W  (REF_W)
    ) u_sem_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (SEM_AW'(req.sem_index[3:0])),
        .rd_count (sem_count),
        .rd_ref   (sem_ref),
        .we       (sem_we),
        .wr_addr  (sem_wr_addr),
        .wr_count (sem_wr_count),
        .wr_ref   (sem_wr_ref),
        .in_use   (in_use)
    );

    cst_slot_store #(
        .ROWS   (NUM_REQUESTERS),
        .ADDR_W (REQ_AW),
        .ROW_W  (ROW_W)
    ) u_slot_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (REQ_AW'(req.requester)),
        .rd_row  (slot_row),
        .we      (slot_we),
        .wr_addr (REQ_AW'(req_reg.requester)),
        .wr_row  (slot_wr_row)
    );

    // Request decode. The range checks guard every use of the read data, so
    // reads at an out-of-range address are harmless.
    assign idx_mag      = req_reg.sem_index[3:0];
    assign idx_addr     = SEM_AW'(idx_mag);
    assign idx_tag      = TAG_W'(idx_mag) + TAG_W'(1);
    assign idx_in_range = !req_reg.sem_index[cst_pkg::INDEX_W-1] &&
                          ({28'd0, idx_mag} < 32'(NUM_SEMS));
    assign is_new       = (req_reg.sem_index == cst_pkg::NEW_INDEX);
    assign req_ok       = ({29'd0, req_reg.requester} < 32'(NUM_REQUESTERS));
    assign sem_held     = (sem_ref != '0);

    // Lowest empty slot and lowest slot holding the requested semaphore.
    always_comb
    begin
        any_empty = 1'b0;
        empty_pos = '0;
        any_match = 1'b0;
        match_pos = '0;
        for (int k = SLOTS_PER_REQUESTER - 1; k >= 0; k--)
        begin
            if (slot_row[k*TAG_W +: TAG_W] == '0)
            begin
                any_empty = 1'b1;
                empty_pos = SLOT_AW'(k);
            end
            if (slot_row[k*TAG_W +: TAG_W] == idx_tag)
            begin
                any_match = 1'b1;
                match_pos = SLOT_AW'(k);
            end
        end
    end

    // Free map scan. Padding bits past the last entry read as taken.
    assign free_vec    = ~in_use;
    assign free_pad    = PAD_W'(free_vec);
    assign grp_vec     = free_pad[grp_reg*cst_pkg::GROUP_W +: cst_pkg::GROUP_W];
    assign grp_found   = |grp_vec;
    assign found_pos   = cst_pkg::lowest_set(grp_vec);
    assign found_entry = SEM_AW'({grp_reg, found_pos});
    assign found_tag   = TAG_W'(found_entry) + TAG_W'(1);

    // Evaluation and write-back. Any failing status leaves both stores as
    // they are; only the success paths raise a write enable.
    always_comb
    begin
        status_next  = status_reg;
        result_next  = result_reg;
        go_search    = 1'b0;
        sem_we       = 1'b0;
        sem_wr_addr  = idx_addr;
        sem_wr_count = sem_count;
        sem_wr_ref   = sem_ref;
        slot_we      = 1'b0;
        slot_wr_row  = slot_row;
        case (state_reg)
            cst_pkg::S_EVAL:
            begin
                status_next = cst_pkg::ST_OK;
                result_next = '0;
                if (req_reg.operation == cst_pkg::OP_GET)
                begin
                    if (!is_new && !idx_in_range)
                    begin
                        status_next = cst_pkg::ST_BAD_INDEX;
                    end
                    else if (!req_ok)
                    begin
                        status_next = cst_pkg::ST_ERROR;
                    end
                    else if (is_new)
                    begin
                        if (!any_empty)
                        begin
                            status_next = cst_pkg::ST_NO_SLOT;
                        end
                        else
                        begin
                            go_search = 1'b1;
                        end
                    end
                    else if (!sem_held)
                    begin
                        status_next = cst_pkg::ST_ERROR;
                    end
                    else if (!any_empty)
                    begin
                        status_next = cst_pkg::ST_NO_SLOT;
                    end
                    else
                    begin
                        sem_we      = 1'b1;
                        sem_wr_ref  = sem_ref + REF_W'(1);
                        slot_we     = 1'b1;
                        slot_wr_row[empty_pos*TAG_W +: TAG_W] = idx_tag;
                        result_next = cst_pkg::RESULT_W'(idx_mag);
                    end
                end
                else if (!idx_in_range || !req_ok || !sem_held || !any_match)
                begin
                    status_next = cst_pkg::ST_ERROR;
                end
                else
                begin
                    case (req_reg.operation)
                        cst_pkg::OP_FREE:
                        begin
                            sem_we     = 1'b1;
                            sem_wr_ref = sem_ref - REF_W'(1);
                            slot_we    = 1'b1;
                            slot_wr_row[match_pos*TAG_W +: TAG_W] = '0;
                        end
                        cst_pkg::OP_DOWN:
                        begin
                            if (sem_count == '0)
                            begin
                                status_next = cst_pkg::ST_WOULD_BLOCK;
                            end
                            else
                            begin
                                sem_we       = 1'b1;
                                sem_wr_count = sem_count - cst_pkg::COUNT_W'(1);
                            end
                        end
                        cst_pkg::OP_UP:
                        begin
                            // Saturates at the maximum count.
                            sem_we = 1'b1;
                            if (sem_count != cst_pkg::COUNT_MAX)
                            begin
                                sem_wr_count = sem_count + cst_pkg::COUNT_W'(1);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            cst_pkg::S_SEARCH:
            begin
                if (grp_found)
                begin
                    sem_we       = 1'b1;
                    sem_wr_addr  = found_entry;
                    sem_wr_count = req_reg.start_count;
                    sem_wr_ref   = REF_W'(1);
                    slot_we      = 1'b1;
                    slot_wr_row[empty_pos*TAG_W +: TAG_W] = found_tag;
                    result_next  = cst_pkg::RESULT_W'(found_entry);
                    status_next  = cst_pkg::ST_OK;
                end
                else if (grp_reg == LAST_GRP)
                begin
                    status_next = cst_pkg::ST_NONE_FREE;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        grp_next   = grp_reg;
        case (state_reg)
            cst_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = cst_pkg::S_EVAL;
                end
            end
            cst_pkg::S_EVAL:
            begin
                grp_next   = '0;
                state_next = go_search ? cst_pkg::S_SEARCH : cst_pkg::S_RESP;
            end
            cst_pkg::S_SEARCH:
            begin
                if (grp_found || (grp_reg == LAST_GRP))
                begin
                    state_next = cst_pkg::S_RESP;
                end
                else
                begin
                    grp_next = grp_reg + GRP_W'(1);
                end
            end
            cst_pkg::S_RESP:
            begin
                if (out_load)
                begin
                    state_next = cst_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cst_pkg::S_IDLE;
            end
        endcase
    end

    // Handshake outputs and the response register load.
    always_comb
    begin
        req.ready      = (state_reg == cst_pkg::S_IDLE);
        out_load       = (state_reg == cst_pkg::S_RESP) && (!out_valid_reg || rsp.ready);
        out_valid_next = out_load || (out_valid_reg && !rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cst_pkg::S_IDLE;
            grp_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            grp_reg       <= grp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.operation   <= req.operation;
            req_reg.requester   <= req.requester;
            req_reg.sem_index   <= req.sem_index;
            req_reg.start_count <= req.start_count;
        end
        status_reg <= status_next;
        result_reg <= result_next;
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_index_reg  <= result_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.result_index = out_index_reg;

`ifndef SYNTHESIS
    // A new semaphore is only searched for when the requester has a free slot.
    a_search_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cst_pkg::S_SEARCH) |-> any_empty)
        else $error("free-entry scan started without an empty requester slot");

    a_grp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cst_pkg::S_SEARCH) |-> (grp_reg <= LAST_GRP))
        else $error("free-entry scan ran past the last group");

    a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        sem_we |-> (status_next == cst_pkg::ST_OK))
        else $error("entry written by a failing request");

    a_slot_with_entry: assert property (@(posedge clk) disable iff (!rst_n)
        slot_we |-> sem_we)
        else $error("slot row changed without a reference count update");

    a_block_on_down: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == cst_pkg::S_RESP) && (status_reg == cst_pkg::ST_WOULD_BLOCK))
        |-> (req_reg.operation == cst_pkg::OP_DOWN))
        else $error("would-block status on an operation other than down");
`endif

endmodule

// ===== tb/sv/counting_semaphore_table_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting semaphore table unit testbench
// Sends get, free, down and up requests through the request channel and
// checks every response against a behavioral copy of the semaphore store.
// The copy keeps its own counts, reference counts and holder slots. A
// directed opening is followed by mostly well-formed random traffic under
// three idling patterns, with one long receiver hold.
// ----------------------------------------------------------------------------
module counting_semaphore_table_unit_test;

    localparam int NUM_SEMS            = 16;
    localparam int SLOTS_PER_REQUESTER = 4;
    localparam int NUM_REQUESTERS      = 8;

    // Random requests queued in each of the three idling phases.
    localparam int RANDOM_PER_PHASE = 340;
    // Quiet cycles after the last response before the next phase starts.
    localparam int DRAIN_CYCLES     = 12;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT      = 200000;

    // The semaphore store is kept twice. The planning copy runs ahead, as
    // requests are queued, so that random traffic can aim at semaphores that
    // a requester really holds. The checking copy advances only when the
    // unit accepts a request, and it alone produces the expected responses.
    localparam int SHADOW_PLAN  = 0;
    localparam int SHADOW_CHECK = 1;

    typedef struct packed {
        cst_pkg::op_t                         operation;
        logic [cst_pkg::REQUESTER_W-1:0]      requester;
        logic signed [cst_pkg::INDEX_W-1:0]   sem_index;
        logic [cst_pkg::COUNT_W-1:0]          start_count;
    } sem_request_t;

    typedef struct packed {
        cst_pkg::status_t                     status;
        logic [cst_pkg::RESULT_W-1:0]         result_index;
    } sem_response_t;

    logic clk = 1'b0;
    logic rst_n;

    cst_req_if req_bus();
    cst_rsp_if rsp_bus();

    counting_semaphore_table_unit #(
        .NUM_SEMS            (NUM_SEMS),
        .SLOTS_PER_REQUESTER (SLOTS_PER_REQUESTER),
        .NUM_REQUESTERS      (NUM_REQUESTERS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Semaphore store: count, number of holders, and per-requester slots.
    // A slot tag of zero is empty; a tag t > 0 names semaphore t - 1.
    logic [cst_pkg::COUNT_W-1:0] sem_count [2][NUM_SEMS];
    int unsigned                 sem_refs  [2][NUM_SEMS];
    logic [cst_pkg::INDEX_W-1:0] slot_tag  [2][NUM_REQUESTERS][SLOTS_PER_REQUESTER];

    sem_request_t  pending_requests[$];
    sem_response_t expected_responses[$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left = 0;
    // The test sequence bumps hold_requests; the hold counter starts a new
    // long hold whenever it has not yet caught up with that number.
    int hold_requests = 0;
    int holds_started = 0;
    int cycle_count = 0;
    int mismatch_count = 0;
    int requests_sent = 0;
    int responses_checked = 0;
    int status_seen[6] = '{default: 0};

    // Driver and monitor scratch values.
    sem_request_t  accepted_rq;
    sem_response_t predicted_rsp;
    sem_response_t oldest_rsp;
    logic          offer_next;

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // Behavioral model of the unit
    // ------------------------------------------------------------------------

    // Lowest slot of requester r whose tag equals tag, or -1 when none does.
    function automatic int find_slot(input int view, input int r, input int tag);
        for (int k = 0; k < SLOTS_PER_REQUESTER; k++)
        begin
            if (slot_tag[view][r][k] == tag)
            begin
                return k;
            end
        end
        return -1;
    endfunction

    // Applies one request to the chosen copy of the store and returns the
    // response the unit must give. Any failing status leaves the copy as it
    // was. The requester field is three bits wide, so every requester number
    // it can carry is a valid one.
    function automatic void serve_request(input int view, input sem_request_t rq,
                                          output sem_response_t rs);
        int idx;
        int r;
        int slot;
        idx = $signed(rq.sem_index);
        r = rq.requester;
        rs.status = cst_pkg::ST_OK;
        rs.result_index = '0;
        if (rq.operation == cst_pkg::OP_GET)
        begin
            if (idx < -1 || idx >= NUM_SEMS)
            begin
                rs.status = cst_pkg::ST_BAD_INDEX;
            end
            else if (idx == -1)
            begin
                // A new semaphore needs a free slot first, then a free entry.
                slot = find_slot(view, r, 0);
                if (slot < 0)
                begin
                    rs.status = cst_pkg::ST_NO_SLOT;
                end
                else
                begin
                    rs.status = cst_pkg::ST_NONE_FREE;
                    for (int e = 0; e < NUM_SEMS && rs.status == cst_pkg::ST_NONE_FREE;
                         e++)
                    begin
                        if (sem_refs[view][e] == 0)
                        begin
                            sem_refs[view][e] = 1;
                            sem_count[view][e] = rq.start_count;
                            slot_tag[view][r][slot] = cst_pkg::INDEX_W'(e + 1);
                            rs.status = cst_pkg::ST_OK;
                            rs.result_index = cst_pkg::RESULT_W'(e);
                        end
                    end
                end
            end
            else if (sem_refs[view][idx] == 0)
            begin
                // Attaching to an unused entry fails before the slot check.
                rs.status = cst_pkg::ST_ERROR;
            end
            else
            begin
                slot = find_slot(view, r, 0);
                if (slot < 0)
                begin
                    rs.status = cst_pkg::ST_NO_SLOT;
                end
                else
                begin
                    sem_refs[view][idx]++;
                    slot_tag[view][r][slot] = cst_pkg::INDEX_W'(idx + 1);
                    rs.result_index = cst_pkg::RESULT_W'(idx);
                end
            end
        end
        else if (idx < 0 || idx >= NUM_SEMS)
        begin
            rs.status = cst_pkg::ST_ERROR;
        end
        else if (sem_refs[view][idx] == 0)
        begin
            rs.status = cst_pkg::ST_ERROR;
        end
        else
        begin
            slot = find_slot(view, r, idx + 1);
            if (slot < 0)
            begin
                rs.status = cst_pkg::ST_ERROR;
            end
            else
            begin
                case (rq.operation)
                    cst_pkg::OP_FREE:
                    begin
                        sem_refs[view][idx]--;
                        slot_tag[view][r][slot] = '0;
                    end
                    cst_pkg::OP_DOWN:
                    begin
                        // A down that would sleep reports it instead.
                        if (sem_count[view][idx] == '0)
                        begin
                            rs.status = cst_pkg::ST_WOULD_BLOCK;
                        end
                        else
                        begin
                            sem_count[view][idx]--;
                        end
                    end
                    default:
                    begin
                        // Up saturates at the largest count.
                        if (sem_count[view][idx] != cst_pkg::COUNT_MAX)
                        begin
                            sem_count[view][idx]++;
                        end
                    end
                endcase
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    task automatic queue_request(input cst_pkg::op_t op, input int r, input int idx,
                                 input int unsigned init);
        sem_request_t  rq;
        sem_response_t ignored;
        rq.operation   = op;
        rq.requester   = cst_pkg::REQUESTER_W'(r);
        rq.sem_index   = cst_pkg::INDEX_W'(idx);
        rq.start_count = cst_pkg::COUNT_W'(init);
        serve_request(SHADOW_PLAN, rq, ignored);
        pending_requests.push_back(rq);
    endtask

    // Initial counts lean toward zero and the maximum, where down blocks and
    // up saturates.
    function automatic int unsigned sample_init();
        case ($urandom_range(3))
            0: return 0;
            1: return cst_pkg::COUNT_MAX;
            2: return $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    // One in five requests is raw noise over every field. The rest act like
    // a well-behaved process: work on a semaphore it holds, or get one.
    task automatic queue_random_request();
        int r;
        int roll;
        int pick;
        int held[$];
        int busy[$];
        r = $urandom_range(NUM_REQUESTERS - 1);
        roll = $urandom_range(99);
        if (roll < 20)
        begin
            queue_request(cst_pkg::op_t'($urandom_range(3)), r, $urandom_range(31),
                          $urandom);
        end
        else
        begin
            for (int k = 0; k < SLOTS_PER_REQUESTER; k++)
            begin
                if (slot_tag[SHADOW_PLAN][r][k] != '0)
                begin
                    held.push_back(int'(slot_tag[SHADOW_PLAN][r][k]) - 1);
                end
            end
            for (int e = 0; e < NUM_SEMS; e++)
            begin
                if (sem_refs[SHADOW_PLAN][e] != 0)
                begin
                    busy.push_back(e);
                end
            end
            if (held.size() != 0 && roll < 84)
            begin
                pick = held[$urandom_range(held.size() - 1)];
                if (roll < 48)
                begin
                    queue_request(cst_pkg::OP_DOWN, r, pick, $urandom);
                end
                else if (roll < 70)
                begin
                    queue_request(cst_pkg::OP_UP, r, pick, $urandom);
                end
                else
                begin
                    queue_request(cst_pkg::OP_FREE, r, pick, $urandom);
                end
            end
            else if (busy.size() != 0 && $urandom_range(1) == 1)
            begin
                queue_request(cst_pkg::OP_GET, r, busy[$urandom_range(busy.size() - 1)],
                              sample_init());
            end
            else
            begin
                queue_request(cst_pkg::OP_GET, r, int'(cst_pkg::NEW_INDEX), sample_init());
            end
        end
    endtask

    // Holds the sender back until every queued request has been answered.
    task automatic wait_until_drained();
        while (pending_requests.size() != 0 || expected_responses.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] wanted,
                                   input logic [31:0] seen);
        $display("[%0t] %s mismatch: expected %0d, got %0d", $time, what, wanted, seen);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Request driver: offers the oldest pending request, holds it until the
    // transaction completes, and feeds each accepted request to the checking
    // copy of the model.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_bus.valid       <= 1'b0;
            req_bus.operation   <= '0;
            req_bus.requester   <= '0;
            req_bus.sem_index   <= '0;
            req_bus.start_count <= '0;
        end
        else
        begin
            if (req_bus.valid && req_bus.ready)
            begin
                accepted_rq = pending_requests.pop_front();
                serve_request(SHADOW_CHECK, accepted_rq, predicted_rsp);
                expected_responses.push_back(predicted_rsp);
                requests_sent++;
            end
            if (pending_requests.size() == 0)
            begin
                offer_next = 1'b0;
            end
            else if (req_bus.valid && !req_bus.ready)
            begin
                // A request on offer stays there until it is taken.
                offer_next = 1'b1;
            end
            else
            begin
                offer_next = ($urandom_range(99) >= send_idle_pct);
            end
            req_bus.valid <= offer_next;
            if (offer_next)
            begin
                req_bus.operation   <= pending_requests[0].operation;
                req_bus.requester   <= pending_requests[0].requester;
                req_bus.sem_index   <= pending_requests[0].sem_index;
                req_bus.start_count <= pending_requests[0].start_count;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response monitor: compares each response transaction with the oldest
    // expectation and throttles ready, either at random or for the whole of
    // a long hold.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
        end
        else
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (expected_responses.size() == 0)
                begin
                    report_mismatch("unrequested response status", 32'hFFFF_FFFF,
                                    rsp_bus.status);
                end
                else
                begin
                    oldest_rsp = expected_responses.pop_front();
                    if (rsp_bus.status !== oldest_rsp.status)
                    begin
                        report_mismatch("status", oldest_rsp.status, rsp_bus.status);
                    end
                    if (rsp_bus.result_index !== oldest_rsp.result_index)
                    begin
                        report_mismatch("result_index", oldest_rsp.result_index,
                                        rsp_bus.result_index);
                    end
                    status_seen[int'(oldest_rsp.status)]++;
                end
                responses_checked++;
            end
            rsp_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Counts down a long receiver hold, started from the stimulus sequence.
    always @(posedge clk)
    begin
        if (holds_started != hold_requests)
        begin
            holds_started <= hold_requests;
            hold_left     <= LONG_HOLD_CYCLES;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Ends a run that has stopped making progress.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        for (int v = 0; v < 2; v++)
        begin
            for (int e = 0; e < NUM_SEMS; e++)
            begin
                sem_count[v][e] = '0;
                sem_refs[v][e] = 0;
            end
            for (int r = 0; r < NUM_REQUESTERS; r++)
            begin
                for (int k = 0; k < SLOTS_PER_REQUESTER; k++)
                begin
                    slot_tag[v][r][k] = '0;
                end
            end
        end
        rst_n = 1'b0;

        // First phase: the sender idles often, the receiver more often.
        send_idle_pct = 36;
        recv_idle_pct = 60;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed opening. Count edges: a down on a zero count blocks, an
        // up at the maximum saturates.
        queue_request(cst_pkg::OP_GET,  0, int'(cst_pkg::NEW_INDEX), 0);       // entry 0
        queue_request(cst_pkg::OP_DOWN, 0, 0, 0);
        queue_request(cst_pkg::OP_UP,   0, 0, 0);
        queue_request(cst_pkg::OP_GET,  1, int'(cst_pkg::NEW_INDEX), 16'hFFFF); // entry 1
        queue_request(cst_pkg::OP_UP,   1, 1, 0);
        // One requester may hold the same entry twice; free drops one copy.
        queue_request(cst_pkg::OP_GET,  2, 1, 0);
        queue_request(cst_pkg::OP_GET,  2, 1, 0);
        queue_request(cst_pkg::OP_FREE, 2, 1, 0);
        queue_request(cst_pkg::OP_DOWN, 2, 1, 0);
        // Unused entries, bad indexes and requests from a non-holder.
        queue_request(cst_pkg::OP_GET,  3, 5, 0);
        queue_request(cst_pkg::OP_GET,  3, -2, 0);
        queue_request(cst_pkg::OP_GET,  3, -16, 0);
        queue_request(cst_pkg::OP_FREE, 3, -1, 0);
        queue_request(cst_pkg::OP_DOWN, 3, 0, 0);
        // Fill every remaining entry: requesters 4 to 6 use all their slots, requester 7 two.
        for (int n = 0; n < NUM_SEMS - 2; n++)
        begin
            queue_request(cst_pkg::OP_GET, 4 + n / SLOTS_PER_REQUESTER,
                          int'(cst_pkg::NEW_INDEX), $urandom);
        end
        queue_request(cst_pkg::OP_UP,   7, 15, 0);
        // A new semaphore with no entry left, then with no slot left.
        queue_request(cst_pkg::OP_GET,  7, int'(cst_pkg::NEW_INDEX), 0);
        queue_request(cst_pkg::OP_GET,  4, int'(cst_pkg::NEW_INDEX), 0);
        // With no slot left, an unused entry is still reported as an error.
        queue_request(cst_pkg::OP_FREE, 5, 6, 0);
        queue_request(cst_pkg::OP_GET,  4, 6, 0);
        for (int n = 0; n < RANDOM_PER_PHASE; n++)
        begin
            queue_random_request();
        end
        wait_until_drained();

        // Second phase: idling the other way round.
        send_idle_pct = 60;
        recv_idle_pct = 36;
        for (int n = 0; n < RANDOM_PER_PHASE; n++)
        begin
            queue_random_request();
        end
        wait_until_drained();

        // Third phase: back-to-back traffic. The receiver opens with a long
        // hold while the sender keeps offering, so the unit backs up and
        // drops its request ready.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int n = 0; n < RANDOM_PER_PHASE; n++)
        begin
            queue_random_request();
        end
        hold_requests++;
        wait_until_drained();

        $display("Run covered %0d requests and %0d responses over three idling phases",
                 requests_sent, responses_checked);
        $display("Statuses: ok %0d, error %0d, no slot %0d, none free %0d,",
                 status_seen[cst_pkg::ST_OK], status_seen[cst_pkg::ST_ERROR],
                 status_seen[cst_pkg::ST_NO_SLOT], status_seen[cst_pkg::ST_NONE_FREE]);
        $display("  bad index %0d, would block %0d",
                 status_seen[cst_pkg::ST_BAD_INDEX], status_seen[cst_pkg::ST_WOULD_BLOCK]);
        if (mismatch_count == 0 && expected_responses.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
